/* src/vidreg_pkg.sv */
// ----------------------------------------------------------------------------
// vidreg_pkg
// Shared types and constants for the video adapter register block.
// ----------------------------------------------------------------------------
package vidreg_pkg;

  // default depth of the crtc register file
  localparam int unsigned CrtcRegsDefault = 256;

  // command codes
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdLine  = 2'd2;
  localparam logic [1:0] CmdBlink = 2'd3;

  // crtc port groups, matched on port[15:3]
  localparam logic [12:0] CrtcMonoGroup  = 13'h076;  // 0x3B0..0x3B7
  localparam logic [12:0] CrtcColorGroup = 13'h07A;  // 0x3D0..0x3D7

  // single ports
  localparam logic [15:0] PortExtMode    = 16'h03B8;
  localparam logic [15:0] PortExtEnable  = 16'h03BF;
  localparam logic [15:0] PortMonoStatus = 16'h03BA;
  localparam logic [15:0] PortMode       = 16'h03D8;
  localparam logic [15:0] PortColor      = 16'h03D9;
  localparam logic [15:0] PortStatus     = 16'h03DA;

  // crtc registers with side effects
  localparam logic [7:0] CrtcCurStart = 8'd10;
  localparam logic [7:0] CrtcCurEnd   = 8'd11;
  localparam logic [7:0] CrtcCurHigh  = 8'd14;
  localparam logic [7:0] CrtcCurLow   = 8'd15;

  // timing and misc constants
  localparam logic [4:0]  CurStartMask   = 5'h1F;
  localparam logic [7:0]  VblankLine     = 8'd224;
  localparam logic [7:0]  StatusBase     = 8'h06;
  localparam logic [7:0]  StatusExt      = 8'hFF;
  localparam logic [15:0] ExtPageBase    = 16'h8000;

  // reset values
  localparam logic [4:0] CurStartReset = 5'd6;
  localparam logic [7:0] CurEndReset   = 8'd7;
  localparam logic [7:0] ModeReset     = 8'h01;
  localparam logic [7:0] ColorReset    = 8'h20;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] port;
    logic [7:0]  wdata;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        cursor_shown;
    logic        blink_phase;
    logic [4:0]  cursor_first_line;
    logic [7:0]  cursor_last_line;
    logic [15:0] cursor_position;
    logic        ext_graphics_on;
    logic [15:0] ext_page_base;
    logic [7:0]  mode_control;
    logic [7:0]  color_select;
  } out_beat_t;

endpackage

/* src/video_adapter_register_block_core.sv */
// ----------------------------------------------------------------------------
// video_adapter_register_block_core
// Port-side register logic of a colour / mono-graphics video adapter: crtc
// index and register file, cursor decode, mode and colour registers, extended
// graphics enable and page, and the retrace status counter.
//
// Usage:
//   The input channel carries one beat per port read, port write, scanline
//   tick or blink tick. Every input beat yields exactly one output beat that
//   shows the read byte (zero unless a read) and the register state after
//   the command. Output valid is set in the cycle after input accept; one
//   beat is accepted every cycle unless the full result register stalls.
//   The rate is set by the single result register; the crtc file RAM is
//   read ahead at the next index so its registered data is ready when a
//   read beat arrives. When the receiver stalls, the output beat holds and
//   the input side stalls only while the result register is full and
//   stalled. The configuration write (cfg_we_i) updates the extended
//   graphics support flag at once. Reset clears all state to its defaults;
//   the crtc file reads as zero through per-entry valid bits, so no
//   clearing pass is needed and the block takes beats right after reset.
// ----------------------------------------------------------------------------
module video_adapter_register_block_core #(
  parameter int unsigned CrtcRegs = vidreg_pkg::CrtcRegsDefault,
  localparam int unsigned AddrW = (CrtcRegs > 1) ? $clog2(CrtcRegs) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vidreg_pkg::in_beat_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vidreg_pkg::out_beat_t out_data_o
);

  // architectural state
  logic        ext_supported_q;
  logic [7:0]  crtc_index_q, crtc_index_d;
  logic [4:0]  cur_start_q, cur_start_d;
  logic [7:0]  cur_end_q, cur_end_d;
  logic        cur_visible_q, cur_visible_d;
  logic [15:0] cur_offset_q, cur_offset_d;
  logic        cur_blink_q, cur_blink_d;
  logic [7:0]  mode_q, mode_d;
  logic [7:0]  color_q, color_d;
  logic [7:0]  status_q, status_d;
  logic [1:0]  ext_enable_q, ext_enable_d;
  logic        ext_graphics_q, ext_graphics_d;
  logic        ext_page_q, ext_page_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  line_q, line_d;

  // crtc file bookkeeping
  logic [CrtcRegs-1:0] valid_q;
  logic                byp_q;
  logic [7:0]          byp_data_q;
  logic [7:0]          ram_rdata;
  logic                ram_we;
  logic                index_in_range;
  logic [7:0]          file_data;

  // output register
  logic                  out_valid_q;
  vidreg_pkg::out_beat_t out_data_q;
  vidreg_pkg::out_beat_t result;
  logic                  in_accept;

  // port decode
  logic is_index_port;
  logic is_data_port;
  logic [7:0] rd_data;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_index_port = ((in_data_i.port[15:3] == vidreg_pkg::CrtcMonoGroup) ||
                          (in_data_i.port[15:3] == vidreg_pkg::CrtcColorGroup)) &&
                         !in_data_i.port[0];
  assign is_data_port  = ((in_data_i.port[15:3] == vidreg_pkg::CrtcMonoGroup) ||
                          (in_data_i.port[15:3] == vidreg_pkg::CrtcColorGroup)) &&
                         in_data_i.port[0];

  assign index_in_range = {1'b0, crtc_index_q} < 9'(CrtcRegs);

  // current crtc file entry: bypass a write from last cycle, unwritten reads 0
  always_comb begin
    file_data = 8'h00;
    if (index_in_range) begin
      if (byp_q) begin
        file_data = byp_data_q;
      end else if (valid_q[crtc_index_q[AddrW-1:0]]) begin
        file_data = ram_rdata;
      end
    end
  end

  // command decode and next state
  always_comb begin
    crtc_index_d   = crtc_index_q;
    cur_start_d    = cur_start_q;
    cur_end_d      = cur_end_q;
    cur_visible_d  = cur_visible_q;
    cur_offset_d   = cur_offset_q;
    cur_blink_d    = cur_blink_q;
    mode_d         = mode_q;
    color_d        = color_q;
    status_d       = status_q;
    ext_enable_d   = ext_enable_q;
    ext_graphics_d = ext_graphics_q;
    ext_page_d     = ext_page_q;
    phase_d        = phase_q;
    line_d         = line_q;
    rd_data        = 8'h00;
    ram_we         = 1'b0;

    if (in_accept) begin
      case (in_data_i.cmd)
        vidreg_pkg::CmdRead: begin
          if (is_index_port) begin
            rd_data = crtc_index_q;
          end else if (is_data_port) begin
            rd_data = file_data;
          end else if (in_data_i.port == vidreg_pkg::PortMode) begin
            rd_data = mode_q;
          end else if (in_data_i.port == vidreg_pkg::PortColor) begin
            rd_data = color_q;
          end else if ((in_data_i.port == vidreg_pkg::PortMonoStatus) ||
                       (in_data_i.port == vidreg_pkg::PortStatus)) begin
            rd_data = ext_graphics_q ? vidreg_pkg::StatusExt : status_q;
          end
        end
        vidreg_pkg::CmdWrite: begin
          if (is_index_port) begin
            crtc_index_d = in_data_i.wdata;
          end else if (is_data_port) begin
            if (index_in_range) begin
              ram_we = 1'b1;
              case (crtc_index_q)
                vidreg_pkg::CrtcCurStart: begin
                  cur_start_d   = in_data_i.wdata[4:0] & vidreg_pkg::CurStartMask;
                  cur_visible_d = !in_data_i.wdata[5] && (cur_start_d < 5'd8);
                end
                vidreg_pkg::CrtcCurEnd:  cur_end_d = in_data_i.wdata;
                vidreg_pkg::CrtcCurHigh: cur_offset_d = {in_data_i.wdata, cur_offset_q[7:0]};
                vidreg_pkg::CrtcCurLow:  cur_offset_d = {cur_offset_q[15:8], in_data_i.wdata};
                default: ;
              endcase
            end
          end else if (in_data_i.port == vidreg_pkg::PortExtMode) begin
            ext_graphics_d = ext_enable_q[0] && in_data_i.wdata[1];
            ext_page_d     = ext_enable_q[1] && in_data_i.wdata[7];
          end else if (in_data_i.port == vidreg_pkg::PortMode) begin
            mode_d = in_data_i.wdata;
          end else if (in_data_i.port == vidreg_pkg::PortColor) begin
            color_d = in_data_i.wdata;
          end else if (in_data_i.port == vidreg_pkg::PortExtEnable) begin
            if (ext_supported_q) begin
              ext_enable_d = in_data_i.wdata[1:0];
            end
          end
        end
        vidreg_pkg::CmdLine: begin
          status_d = vidreg_pkg::StatusBase |
                     {4'b0000, (line_q >= vidreg_pkg::VblankLine), 2'b00,
                      (phase_q == 2'd3)};
          phase_d  = phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            line_d = line_q + 8'd1;
          end
        end
        vidreg_pkg::CmdBlink: begin
          cur_blink_d = !cur_blink_q;
        end
        default: ;
      endcase
    end
  end

  // result beat shows the state after the command
  always_comb begin
    result.read_data         = rd_data;
    result.cursor_shown      = cur_visible_d;
    result.blink_phase       = cur_blink_d;
    result.cursor_first_line = cur_start_d;
    result.cursor_last_line  = cur_end_d;
    result.cursor_position   = cur_offset_d;
    result.ext_graphics_on   = ext_graphics_d;
    result.ext_page_base     = ext_page_d ? vidreg_pkg::ExtPageBase : 16'h0000;
    result.mode_control      = mode_d;
    result.color_select      = color_d;
  end

  // crtc file, read ahead at the next index
  vidreg_ram #(
    .Width (8),
    .Depth (CrtcRegs)
  ) u_crtc_file (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (crtc_index_q[AddrW-1:0]),
    .wdata_i (in_data_i.wdata),
    .raddr_i (crtc_index_d[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // write-through bypass for a read right after a write at the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ram_we && (crtc_index_d == crtc_index_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      byp_data_q <= in_data_i.wdata;
    end
  end

  // valid bit per crtc file entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[crtc_index_q[AddrW-1:0]] <= 1'b1;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_supported_q <= 1'b1;
    end else if (cfg_we_i) begin
      ext_supported_q <= cfg_wdata_i;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crtc_index_q   <= 8'h00;
      cur_start_q    <= vidreg_pkg::CurStartReset;
      cur_end_q      <= vidreg_pkg::CurEndReset;
      cur_visible_q  <= 1'b1;
      cur_offset_q   <= 16'h0000;
      cur_blink_q    <= 1'b0;
      mode_q         <= vidreg_pkg::ModeReset;
      color_q        <= vidreg_pkg::ColorReset;
      status_q       <= 8'h00;
      ext_enable_q   <= 2'b00;
      ext_graphics_q <= 1'b0;
      ext_page_q     <= 1'b0;
      phase_q        <= 2'd0;
      line_q         <= 8'd0;
    end else begin
      crtc_index_q   <= crtc_index_d;
      cur_start_q    <= cur_start_d;
      cur_end_q      <= cur_end_d;
      cur_visible_q  <= cur_visible_d;
      cur_offset_q   <= cur_offset_d;
      cur_blink_q    <= cur_blink_d;
      mode_q         <= mode_d;
      color_q        <= color_d;
      status_q       <= status_d;
      ext_enable_q   <= ext_enable_d;
      ext_graphics_q <= ext_graphics_d;
      ext_page_q     <= ext_page_d;
      phase_q        <= phase_d;
      line_q         <= line_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/vidreg_ram.sv */
// ----------------------------------------------------------------------------
// vidreg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vidreg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/video_adapter_register_block_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_adapter_register_block_core_test
// Self-checking bench for the video adapter register block. Port reads and
// writes, scanline ticks and blink ticks are driven with random idle and
// stall bursts. A scoreboard predicts every output beat from its own copy of
// the register state and compares the beats field by field.
// ----------------------------------------------------------------------------
module video_adapter_register_block_core_test;

  localparam int CrtcDepth  = int'(vidreg_pkg::CrtcRegsDefault);
  localparam int CycleLimit = 500000;

  // scoreboard: register state of the adapter plus the expected output beats
  class vid_reg_scoreboard;
    logic [7:0]  crtc_idx;
    logic [7:0]  crtc_regs [CrtcDepth];
    logic [4:0]  cur_first;
    logic [7:0]  cur_last;
    logic        cur_vis;
    logic [15:0] cur_pos;
    logic        blink;
    logic [7:0]  mode_byte;
    logic [7:0]  color_byte;
    logic [7:0]  status_byte;
    logic [1:0]  ext_en;
    logic        ext_gfx;
    logic        ext_page;
    logic [1:0]  retrace;
    logic [7:0]  line_cnt;
    logic        ext_supported;
    vidreg_pkg::out_beat_t expected_q [$];
    int          errors;

    function new();
      crtc_idx = '0;
      foreach (crtc_regs[i]) crtc_regs[i] = '0;
      cur_first = vidreg_pkg::CurStartReset;
      cur_last = vidreg_pkg::CurEndReset;
      cur_vis = 1'b1;
      cur_pos = '0;
      blink = 1'b0;
      mode_byte = vidreg_pkg::ModeReset;
      color_byte = vidreg_pkg::ColorReset;
      status_byte = '0;
      ext_en = '0;
      ext_gfx = 1'b0;
      ext_page = 1'b0;
      retrace = '0;
      line_cnt = '0;
      ext_supported = 1'b1;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted input beat and queue the beat it must produce
    function void note_input(vidreg_pkg::in_beat_t b);
      vidreg_pkg::out_beat_t r;
      logic      crtc_hit;
      logic      in_file;
      r = '0;
      crtc_hit = (b.port[15:3] == vidreg_pkg::CrtcMonoGroup) ||
                 (b.port[15:3] == vidreg_pkg::CrtcColorGroup);
      in_file = int'(crtc_idx) < CrtcDepth;
      case (b.cmd)
        vidreg_pkg::CmdRead: begin
          if (crtc_hit && !b.port[0]) r.read_data = crtc_idx;
          else if (crtc_hit) r.read_data = in_file ? crtc_regs[crtc_idx] : 8'h00;
          else if (b.port == vidreg_pkg::PortMode) r.read_data = mode_byte;
          else if (b.port == vidreg_pkg::PortColor) r.read_data = color_byte;
          else if (b.port == vidreg_pkg::PortStatus || b.port == vidreg_pkg::PortMonoStatus)
            r.read_data = ext_gfx ? vidreg_pkg::StatusExt : status_byte;
        end
        vidreg_pkg::CmdWrite: begin
          if (crtc_hit && !b.port[0]) begin
            crtc_idx = b.wdata;
          end else if (crtc_hit) begin
            if (in_file) begin
              crtc_regs[crtc_idx] = b.wdata;
              // cursor registers decode on write
              case (crtc_idx)
                vidreg_pkg::CrtcCurStart: begin
                  cur_first = b.wdata[4:0] & vidreg_pkg::CurStartMask;
                  cur_vis = !b.wdata[5] && (cur_first < 5'd8);
                end
                vidreg_pkg::CrtcCurEnd:  cur_last = b.wdata;
                vidreg_pkg::CrtcCurHigh: cur_pos[15:8] = b.wdata;
                vidreg_pkg::CrtcCurLow:  cur_pos[7:0] = b.wdata;
                default: ;
              endcase
            end
          end else if (b.port == vidreg_pkg::PortExtMode) begin
            ext_gfx = ext_en[0] & b.wdata[1];
            ext_page = ext_en[1] & b.wdata[7];
          end else if (b.port == vidreg_pkg::PortMode) begin
            mode_byte = b.wdata;
          end else if (b.port == vidreg_pkg::PortColor) begin
            color_byte = b.wdata;
          end else if (b.port == vidreg_pkg::PortExtEnable) begin
            if (ext_supported) ext_en = b.wdata[1:0];
          end
        end
        vidreg_pkg::CmdLine: begin
          // retrace bit in the last phase, vblank bit from the vblank line on
          status_byte = vidreg_pkg::StatusBase |
                        {4'b0, line_cnt >= vidreg_pkg::VblankLine, 2'b0, retrace == 2'd3};
          retrace = retrace + 2'd1;
          if (retrace == 2'd0) line_cnt = line_cnt + 8'd1;
        end
        vidreg_pkg::CmdBlink: blink = ~blink;
        default: ;
      endcase
      r.cursor_shown = cur_vis;
      r.blink_phase = blink;
      r.cursor_first_line = cur_first;
      r.cursor_last_line = cur_last;
      r.cursor_position = cur_pos;
      r.ext_graphics_on = ext_gfx;
      r.ext_page_base = ext_page ? vidreg_pkg::ExtPageBase : 16'h0000;
      r.mode_control = mode_byte;
      r.color_select = color_byte;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted output beat with the oldest expectation
    function void check_result(vidreg_pkg::out_beat_t got);
      vidreg_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        $error("output beat with no expected result");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
      compare_field("cursor_shown", 16'(want.cursor_shown), 16'(got.cursor_shown));
      compare_field("blink_phase", 16'(want.blink_phase), 16'(got.blink_phase));
      compare_field("cursor_first_line", 16'(want.cursor_first_line),
                    16'(got.cursor_first_line));
      compare_field("cursor_last_line", 16'(want.cursor_last_line),
                    16'(got.cursor_last_line));
      compare_field("cursor_position", want.cursor_position, got.cursor_position);
      compare_field("ext_graphics_on", 16'(want.ext_graphics_on), 16'(got.ext_graphics_on));
      compare_field("ext_page_base", want.ext_page_base, got.ext_page_base);
      compare_field("mode_control", 16'(want.mode_control), 16'(got.mode_control));
      compare_field("color_select", 16'(want.color_select), 16'(got.color_select));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  vidreg_pkg::in_beat_t  in_data = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  vidreg_pkg::out_beat_t out_data_o;

  int idle_pct = 0;
  int cycle_count = 0;
  vid_reg_scoreboard board = new();

  video_adapter_register_block_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // beat monitor: inputs noted before outputs checked
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) board.note_input(in_data);
      if (out_valid_o && !out_stall) board.check_result(out_data_o);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 299) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // send one input beat, with an optional idle burst before it
  task automatic issue_beat(input logic [1:0] cmd_v, input logic [15:0] port_v,
                            input logic [7:0] data_v);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd_v, port_v, data_v};
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic drain_block();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // write the extended graphics support flag while idle
  task automatic write_ext_support(input logic value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.ext_supported = value;
  endtask

  // index write then a few data or index accesses through one crtc group
  task automatic crtc_sequence(inout int count);
    logic [12:0] grp;
    logic [1:0]  sel;
    logic [7:0]  idx;
    int          accesses;
    grp = $urandom_range(0, 1) ? vidreg_pkg::CrtcMonoGroup : vidreg_pkg::CrtcColorGroup;
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 3))
        0: idx = vidreg_pkg::CrtcCurStart;
        1: idx = vidreg_pkg::CrtcCurEnd;
        2: idx = vidreg_pkg::CrtcCurHigh;
        default: idx = vidreg_pkg::CrtcCurLow;
      endcase
    end else begin
      idx = 8'($urandom);
    end
    sel = 2'($urandom_range(0, 3));
    issue_beat(vidreg_pkg::CmdWrite, {grp, sel, 1'b0}, idx);
    accesses = $urandom_range(1, 4);
    repeat (accesses) begin
      sel = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: issue_beat(vidreg_pkg::CmdWrite, {grp, sel, 1'b1}, 8'($urandom));
        6, 7, 8: issue_beat(vidreg_pkg::CmdRead, {grp, sel, 1'b1}, 8'($urandom));
        default: issue_beat(vidreg_pkg::CmdRead, {grp, sel, 1'b0}, 8'($urandom));
      endcase
    end
    count += 1 + accesses;
  endtask

  // one random section of mixed sequences
  task automatic random_phase(input int target, input bit calm);
    int          count;
    int          kind;
    int          n;
    logic [15:0] p;
    count = 0;
    while (count < target) begin
      if (calm) idle_pct = 0;
      else if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0, 1: idle_pct = 0;
          2: idle_pct = 10;
          3: idle_pct = 30;
          default: idle_pct = 60;
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // noise on any port
        issue_beat(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        count++;
      end else if (kind < 50) begin
        crtc_sequence(count);
      end else if (kind < 75) begin
        case ($urandom_range(0, 5))
          0: p = vidreg_pkg::PortMode;
          1: p = vidreg_pkg::PortColor;
          2: p = vidreg_pkg::PortStatus;
          3: p = vidreg_pkg::PortMonoStatus;
          4: p = vidreg_pkg::PortExtMode;
          default: p = vidreg_pkg::PortExtEnable;
        endcase
        issue_beat($urandom_range(0, 1) ? vidreg_pkg::CmdWrite : vidreg_pkg::CmdRead, p,
                   8'($urandom));
        count++;
      end else begin
        // run of scanline ticks with blink ticks and status reads mixed in
        n = $urandom_range(8, 56);
        repeat (n) begin
          kind = $urandom_range(0, 99);
          if (kind < 80) issue_beat(vidreg_pkg::CmdLine, 16'($urandom), 8'($urandom));
          else if (kind < 90) issue_beat(vidreg_pkg::CmdBlink, 16'($urandom), 8'($urandom));
          else issue_beat(vidreg_pkg::CmdRead,
                          $urandom_range(0, 1) ? vidreg_pkg::PortStatus
                                               : vidreg_pkg::PortMonoStatus, 8'h00);
        end
        count += n;
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    write_ext_support(1'b1);

    // directed: reset values, unlisted ports, cursor decode, extended mode
    issue_beat(vidreg_pkg::CmdRead, vidreg_pkg::PortMode, 8'h00);
    issue_beat(vidreg_pkg::CmdRead, vidreg_pkg::PortColor, 8'h00);
    issue_beat(vidreg_pkg::CmdRead, vidreg_pkg::PortStatus, 8'h00);
    issue_beat(vidreg_pkg::CmdRead, 16'hFFFF, 8'hFF);
    issue_beat(vidreg_pkg::CmdWrite, 16'h0000, 8'hFF);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcColorGroup, 3'b100},
               vidreg_pkg::CrtcCurStart);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcColorGroup, 3'b101}, 8'h07);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcColorGroup, 3'b101}, 8'h28);
    issue_beat(vidreg_pkg::CmdRead, {vidreg_pkg::CrtcColorGroup, 3'b101}, 8'h00);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcMonoGroup, 3'b100},
               vidreg_pkg::CrtcCurEnd);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcMonoGroup, 3'b101}, 8'hFF);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcColorGroup, 3'b000},
               vidreg_pkg::CrtcCurHigh);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcColorGroup, 3'b111}, 8'hAB);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcColorGroup, 3'b110},
               vidreg_pkg::CrtcCurLow);
    issue_beat(vidreg_pkg::CmdWrite, {vidreg_pkg::CrtcMonoGroup, 3'b001}, 8'hCD);
    issue_beat(vidreg_pkg::CmdWrite, vidreg_pkg::PortExtEnable, 8'h03);
    issue_beat(vidreg_pkg::CmdWrite, vidreg_pkg::PortExtMode, 8'h82);
    issue_beat(vidreg_pkg::CmdRead, vidreg_pkg::PortMonoStatus, 8'h00);
    issue_beat(vidreg_pkg::CmdRead, vidreg_pkg::PortExtMode, 8'h00);
    issue_beat(vidreg_pkg::CmdRead, vidreg_pkg::PortExtEnable, 8'h00);
    issue_beat(vidreg_pkg::CmdLine, 16'h0000, 8'h00);
    issue_beat(vidreg_pkg::CmdBlink, 16'hFFFF, 8'hFF);
    issue_beat(vidreg_pkg::CmdWrite, vidreg_pkg::PortMode, 8'h00);
    issue_beat(vidreg_pkg::CmdWrite, vidreg_pkg::PortColor, 8'hFF);
    issue_beat(vidreg_pkg::CmdWrite, vidreg_pkg::PortExtMode, 8'h00);

    // random sections, support flag toggled between them
    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      write_ext_support(ph[0]);
      random_phase(315, ph == 5);
    end

    drain_block();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
src/vidreg_pkg.sv
src/vidreg_ram.sv
src/video_adapter_register_block_core.sv
tb/video_adapter_register_block_core_test.sv
